@@ hw/rtl/gdd_pkg.sv @@
`default_nettype none

package gdd_pkg;

    // Field widths of the item formats.
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int DIFF_W   = 22;
    localparam int WDAY_W   = 3;

    // A day number of any 14-bit year fits in 23 bits.
    localparam int DAYNUM_W = 23;

    localparam int MAX_YEAR_DEF = 9999;

    // Register stages inside one lane.
    localparam int LANE_STAGES = 5;

    // Difference saturates at the all-ones value of the result field.
    localparam logic [DIFF_W-1:0] DAYS_SAT = '1;

    // Division by 100 of a year: (y * 5243) >> 19 is exact for y < 16384.
    localparam int RECIP_100    = 5243;
    localparam int RECIP_100_W  = 13;
    localparam int RECIP_100_SH = 19;
    localparam int YPROD_W      = YEAR_W + RECIP_100_W;
    localparam int CENT_W       = YPROD_W - RECIP_100_SH;

    // Division by 7 of the biased Zeller sum: (x * 1171) >> 13 is exact for x < 1024.
    localparam int ZSUM_W      = 10;
    localparam int RECIP_7     = 1171;
    localparam int RECIP_7_W   = 11;
    localparam int RECIP_7_SH  = 13;
    localparam int ZPROD_W     = ZSUM_W + RECIP_7_W;
    localparam int ZQ_W        = ZPROD_W - RECIP_7_SH;

    // Multiple of 7 added so that the Zeller sum never goes negative.
    localparam int WDAY_BIAS   = 329;

    localparam int ZTERM_W     = 6;
    localparam int MBEFORE_W   = 9;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
    } gdd_in_t;

    typedef struct packed {
        logic               dates_valid;
        logic [DIFF_W-1:0]  days_between;
        logic [WDAY_W-1:0]  start_weekday;
    } gdd_out_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        logic                date_ok;
        logic [DAYNUM_W-1:0] day_num;
        logic [WDAY_W-1:0]   weekday;
    } lane_res_t;

    typedef logic [LANE_STAGES-1:0] stage_en_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months ahead of month m of a common year.
    function automatic logic [MBEFORE_W-1:0] month_before(input logic [MONTH_W-1:0] m);
        logic [MBEFORE_W-1:0] n;
        case (m)
            MONTH_JAN: n = 9'd0;
            MONTH_FEB: n = 9'd31;
            MONTH_MAR: n = 9'd59;
            MONTH_APR: n = 9'd90;
            MONTH_MAY: n = 9'd120;
            MONTH_JUN: n = 9'd151;
            MONTH_JUL: n = 9'd181;
            MONTH_AUG: n = 9'd212;
            MONTH_SEP: n = 9'd243;
            MONTH_OCT: n = 9'd273;
            MONTH_NOV: n = 9'd304;
            MONTH_DEC: n = 9'd334;
            default:   n = 9'd0;
        endcase
        return n;
    endfunction

    // Zeller month term (13 * (mm + 1)) / 5, where months below March count
    // as months 12 to 14 of the previous year.
    function automatic logic [ZTERM_W-1:0] zeller_month_term(input logic [MONTH_W-1:0] m);
        logic [ZTERM_W-1:0] t;
        case (m)
            4'd0:      t = 6'd33;
            MONTH_JAN: t = 6'd36;
            MONTH_FEB: t = 6'd39;
            MONTH_MAR: t = 6'd10;
            MONTH_APR: t = 6'd13;
            MONTH_MAY: t = 6'd15;
            MONTH_JUN: t = 6'd18;
            MONTH_JUL: t = 6'd20;
            MONTH_AUG: t = 6'd23;
            MONTH_SEP: t = 6'd26;
            MONTH_OCT: t = 6'd28;
            MONTH_NOV: t = 6'd31;
            MONTH_DEC: t = 6'd33;
            4'd13:     t = 6'd36;
            4'd14:     t = 6'd39;
            4'd15:     t = 6'd41;
            default:   t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gdd_ifs.sv @@
`default_nettype none

// Channel that carries a pair of dates.
interface gdd_in_if;
    logic             valid;
    logic             ready;
    gdd_pkg::gdd_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Channel that carries one result item.
interface gdd_out_if;
    logic              valid;
    logic              ready;
    gdd_pkg::gdd_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gdd_lane.sv @@
`default_nettype none

// One date lane: validity, day number since 1 January of year 1, and the
// Zeller weekday. Pure datapath; stage i loads when en[i] is high.
module gdd_lane #(
    parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
    input  wire logic               clk,
    input  wire gdd_pkg::date_t     date,
    input  wire gdd_pkg::stage_en_t en,
    output gdd_pkg::lane_res_t      res
);

    localparam int YCMP_W = 16;
    localparam logic [YCMP_W-1:0] YEAR_LIMIT = YCMP_W'(MAX_YEAR);

    // Stage 1: products.
    logic [gdd_pkg::DAY_W-1:0]    d1_reg;
    logic [gdd_pkg::MONTH_W-1:0]  m1_reg;
    logic [gdd_pkg::YEAR_W-1:0]   y1_reg, y1_next;
    logic [gdd_pkg::YEAR_W-1:0]   p1_reg, p1_next;
    logic [gdd_pkg::DAYNUM_W-1:0] p365_reg, p365_next;
    logic [gdd_pkg::YPROD_W-1:0]  pprod_reg, pprod_next;
    logic [gdd_pkg::YPROD_W-1:0]  yprod_reg, yprod_next;
    logic [gdd_pkg::YPROD_W-1:0]  zprod_reg, zprod_next;
    logic [gdd_pkg::YEAR_W-1:0]   zy_reg, zy_next;
    logic                         zneg1_reg, zneg1_next;
    logic [gdd_pkg::ZTERM_W-1:0]  zmt1_reg, zmt1_next;
    logic                         early;

    // Stage 2: year base, leap flag, Zeller century split.
    logic [gdd_pkg::DAY_W-1:0]    d2_reg;
    logic [gdd_pkg::MONTH_W-1:0]  m2_reg;
    logic [gdd_pkg::DAYNUM_W-1:0] base_reg, base_next;
    logic                         leap_reg, leap_next;
    logic                         yok_reg, yok_next;
    logic [6:0]                   k_reg, k_next;
    logic [gdd_pkg::CENT_W-1:0]   j_reg;
    logic                         zneg2_reg;
    logic [gdd_pkg::ZTERM_W-1:0]  zmt2_reg;
    logic [gdd_pkg::CENT_W-1:0]   pq100, yq100, zq100;

    // Stage 3: day number, validity, biased Zeller sum.
    logic                         ok3_reg, ok3_next;
    logic [gdd_pkg::DAYNUM_W-1:0] n3_reg, n3_next;
    logic [gdd_pkg::ZSUM_W-1:0]   x3_reg, x3_next;
    logic [gdd_pkg::DAY_W-1:0]    mlen;
    logic [gdd_pkg::ZSUM_W-1:0]   zpos, zsub;

    // Stage 4: reciprocal product for the mod 7.
    logic                         ok4_reg;
    logic [gdd_pkg::DAYNUM_W-1:0] n4_reg;
    logic [gdd_pkg::ZSUM_W-1:0]   x4_reg;
    logic [gdd_pkg::ZPROD_W-1:0]  zp4_reg, zp4_next;

    // Stage 5: weekday.
    logic                         ok5_reg;
    logic [gdd_pkg::DAYNUM_W-1:0] n5_reg;
    logic [gdd_pkg::WDAY_W-1:0]   wd5_reg, wd5_next;
    logic [gdd_pkg::ZQ_W-1:0]     zq7;

    always_comb
    begin
        y1_next    = date.year;
        p1_next    = date.year - gdd_pkg::YEAR_W'(1);
        p365_next  = gdd_pkg::DAYNUM_W'(p1_next) * gdd_pkg::DAYNUM_W'(365);
        pprod_next = gdd_pkg::YPROD_W'(p1_next) * gdd_pkg::YPROD_W'(gdd_pkg::RECIP_100);
        yprod_next = gdd_pkg::YPROD_W'(date.year) * gdd_pkg::YPROD_W'(gdd_pkg::RECIP_100);
        early      = date.month < gdd_pkg::MONTH_MAR;
        zy_next    = early ? date.year - gdd_pkg::YEAR_W'(1) : date.year;
        zneg1_next = early && (date.year == '0);
        zprod_next = gdd_pkg::YPROD_W'(zy_next) * gdd_pkg::YPROD_W'(gdd_pkg::RECIP_100);
        zmt1_next  = gdd_pkg::zeller_month_term(date.month);
    end

    always_comb
    begin
        pq100     = pprod_reg[gdd_pkg::RECIP_100_SH +: gdd_pkg::CENT_W];
        yq100     = yprod_reg[gdd_pkg::RECIP_100_SH +: gdd_pkg::CENT_W];
        zq100     = zprod_reg[gdd_pkg::RECIP_100_SH +: gdd_pkg::CENT_W];
        base_next = p365_reg + gdd_pkg::DAYNUM_W'(p1_reg >> 2)
                  - gdd_pkg::DAYNUM_W'(pq100) + gdd_pkg::DAYNUM_W'(pq100 >> 2);
        // Divisible by 100 when the remainder is zero; by 400 when the
        // century count is also a multiple of four.
        leap_next = (y1_reg[1:0] == 2'b00)
                  && ((y1_reg != gdd_pkg::YEAR_W'(yq100) * gdd_pkg::YEAR_W'(100))
                      || (yq100[1:0] == 2'b00));
        yok_next  = (y1_reg != '0) && (YCMP_W'(y1_reg) <= YEAR_LIMIT);
        k_next    = 7'(zy_reg - gdd_pkg::YEAR_W'(zq100) * gdd_pkg::YEAR_W'(100));
    end

    always_comb
    begin
        mlen     = gdd_pkg::month_len(m2_reg, leap_reg);
        ok3_next = yok_reg && (m2_reg >= gdd_pkg::MONTH_JAN) && (m2_reg <= gdd_pkg::MONTH_DEC)
                 && (d2_reg != '0) && (d2_reg <= mlen);
        n3_next  = base_reg + gdd_pkg::DAYNUM_W'(gdd_pkg::month_before(m2_reg))
                 + gdd_pkg::DAYNUM_W'(leap_reg && (m2_reg > gdd_pkg::MONTH_FEB))
                 + gdd_pkg::DAYNUM_W'(d2_reg);
        // Year -1 (January or February of year 0) gives k = -1, j = 0.
        if (zneg2_reg)
        begin
            zpos = gdd_pkg::ZSUM_W'(d2_reg) + gdd_pkg::ZSUM_W'(zmt2_reg)
                 + gdd_pkg::ZSUM_W'(gdd_pkg::WDAY_BIAS);
            zsub = gdd_pkg::ZSUM_W'(1);
        end
        else
        begin
            zpos = gdd_pkg::ZSUM_W'(d2_reg) + gdd_pkg::ZSUM_W'(zmt2_reg)
                 + gdd_pkg::ZSUM_W'(gdd_pkg::WDAY_BIAS) + gdd_pkg::ZSUM_W'(k_reg)
                 + gdd_pkg::ZSUM_W'(k_reg >> 2) + gdd_pkg::ZSUM_W'(j_reg >> 2);
            zsub = gdd_pkg::ZSUM_W'({j_reg, 1'b0});
        end
        x3_next = zpos - zsub;
    end

    always_comb
    begin
        zp4_next = gdd_pkg::ZPROD_W'(x3_reg) * gdd_pkg::ZPROD_W'(gdd_pkg::RECIP_7);
        zq7      = zp4_reg[gdd_pkg::RECIP_7_SH +: gdd_pkg::ZQ_W];
        wd5_next = gdd_pkg::WDAY_W'(x4_reg - gdd_pkg::ZSUM_W'(zq7) * gdd_pkg::ZSUM_W'(7));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d1_reg    <= date.day;
            m1_reg    <= date.month;
            y1_reg    <= y1_next;
            p1_reg    <= p1_next;
            p365_reg  <= p365_next;
            pprod_reg <= pprod_next;
            yprod_reg <= yprod_next;
            zprod_reg <= zprod_next;
            zy_reg    <= zy_next;
            zneg1_reg <= zneg1_next;
            zmt1_reg  <= zmt1_next;
        end
        if (en[1])
        begin
            d2_reg    <= d1_reg;
            m2_reg    <= m1_reg;
            base_reg  <= base_next;
            leap_reg  <= leap_next;
            yok_reg   <= yok_next;
            k_reg     <= k_next;
            j_reg     <= zq100;
            zneg2_reg <= zneg1_reg;
            zmt2_reg  <= zmt1_reg;
        end
        if (en[2])
        begin
            ok3_reg <= ok3_next;
            n3_reg  <= n3_next;
            x3_reg  <= x3_next;
        end
        if (en[3])
        begin
            ok4_reg <= ok3_reg;
            n4_reg  <= n3_reg;
            x4_reg  <= x3_reg;
            zp4_reg <= zp4_next;
        end
        if (en[4])
        begin
            ok5_reg <= ok4_reg;
            n5_reg  <= n4_reg;
            wd5_reg <= wd5_next;
        end
    end

    assign res.date_ok = ok5_reg;
    assign res.day_num = n5_reg;
    assign res.weekday = wd5_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gdd_merge.sv @@
`default_nettype none

// Combines the two lanes into one result item and holds it in the output
// register.
module gdd_merge (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire gdd_pkg::lane_res_t start_res,
    input  wire gdd_pkg::lane_res_t end_res,
    output gdd_pkg::gdd_out_t       res
);

    logic                         both_ok;
    logic                         later;
    logic [gdd_pkg::DAYNUM_W-1:0] diff;
    logic [gdd_pkg::DIFF_W-1:0]   days_next;
    gdd_pkg::gdd_out_t            res_reg;

    always_comb
    begin
        both_ok = start_res.date_ok && end_res.date_ok;
        later   = end_res.day_num > start_res.day_num;
        diff    = end_res.day_num - start_res.day_num;
        if (!(both_ok && later))
        begin
            days_next = '0;
        end
        else if (diff > gdd_pkg::DAYNUM_W'(gdd_pkg::DAYS_SAT))
        begin
            days_next = gdd_pkg::DAYS_SAT;
        end
        else
        begin
            days_next = gdd_pkg::DIFF_W'(diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.dates_valid   <= both_ok;
            res_reg.days_between  <= days_next;
            res_reg.start_weekday <= start_res.weekday;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gregorian_date_difference_core.sv @@
`default_nettype none

// Channel   Role    Item
// -------   -----   ---------------------------------------------------------
// dates     sink    start and end date: day, month, year of each
// result    source  dates_valid, days_between, start_weekday
//
// One item is accepted per cycle, sustained while result.ready is high. The
// first lane stage loads at the accepting edge, four more lane stages follow,
// and the output register holds the merged result.
// Reset (rst_n, asynchronous, active low) clears only the valid bits.
// dates.ready falls only when every lane stage and the output register hold an
// item and result.ready is low; empty stages are filled on the way.
module gregorian_date_difference_core #(
    parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gdd_in_if.sink     dates,
    gdd_out_if.source  result
);

    localparam int NS = gdd_pkg::LANE_STAGES;

    // Valid bit of each lane stage, and of the output register.
    logic [NS-1:0] vld_reg, vld_next;
    logic          out_vld_reg;

    // take[i]: stage i may load this cycle. take[NS] is the output register.
    logic [NS:0]   take;

    gdd_pkg::date_t     start_date, end_date;
    gdd_pkg::lane_res_t start_res, end_res;
    gdd_pkg::gdd_out_t  merged;

    always_comb
    begin
        take[NS] = !out_vld_reg || result.ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            take[i] = !vld_reg[i] || take[i+1];
        end
        vld_next[0] = take[0] ? dates.valid : vld_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            vld_next[i] = take[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (take[NS])
            begin
                out_vld_reg <= vld_reg[NS-1];
            end
        end
    end

    // Each date goes down its own lane; both lanes step together.
    always_comb
    begin
        start_date.day   = dates.data.start_day;
        start_date.month = dates.data.start_month;
        start_date.year  = dates.data.start_year;
        end_date.day     = dates.data.end_day;
        end_date.month   = dates.data.end_month;
        end_date.year    = dates.data.end_year;
    end

    gdd_lane #(
        .MAX_YEAR (MAX_YEAR)
    ) u_start_lane (
        .clk  (clk),
        .date (start_date),
        .en   (take[NS-1:0]),
        .res  (start_res)
    );

    gdd_lane #(
        .MAX_YEAR (MAX_YEAR)
    ) u_end_lane (
        .clk  (clk),
        .date (end_date),
        .en   (take[NS-1:0]),
        .res  (end_res)
    );

    // The merge compares the two day numbers and takes the start weekday.
    gdd_merge u_merge (
        .clk       (clk),
        .en        (take[NS]),
        .start_res (start_res),
        .end_res   (end_res),
        .res       (merged)
    );

    assign dates.ready  = take[0];
    assign result.valid = out_vld_reg;
    assign result.data  = merged;

    // The input side only stalls when every stage holds an item and the
    // output cannot drain.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !dates.ready |-> ((&vld_reg) && out_vld_reg && !result.ready))
        else $error("input stalled while the pipeline had a free slot");

    // An invalid pair never reports a day count.
    a_invalid_zero_days: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.data.dates_valid) |-> (result.data.days_between == '0))
        else $error("nonzero day count for invalid dates");

    // The weekday code stays within Saturday to Friday.
    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.start_weekday <= gdd_pkg::WDAY_W'(6)))
        else $error("weekday code out of range");

    // A result that is taken frees the output register unless a new item
    // arrives from the last lane stage in the same cycle.
    a_output_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !vld_reg[NS-1]) |=> !result.valid)
        else $error("output register kept a delivered item");

endmodule

`default_nettype wire
